// ----- rtl/twma_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twma_pkg
// Shared register indexes and config width for the weighted moving average unit.
// ----------------------------------------------------------------------------
package twma_pkg;
	localparam logic REG_WINDOW_WIDTH = 1'b0;
	localparam logic REG_WEIGHT_MODE  = 1'b1;
	localparam int   CFG_BITS         = 6;
endpackage

// ----- rtl/twma_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twma_cell
// One history tap: holds a sample and passes it to the older neighbor on shift.
// ----------------------------------------------------------------------------
module twma_cell #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                   clk,
	input  logic                   shift,
	input  logic [SAMPLE_BITS-1:0] din,
	output logic [SAMPLE_BITS-1:0] dout
);
	logic [SAMPLE_BITS-1:0] val_q;
	always_ff @(posedge clk) begin
		if (shift) begin
			val_q <= din;
		end
	end
	assign dout = val_q;
endmodule

// ----- rtl/trailing_weighted_moving_average_unit.sv -----
`timescale 1ns / 1ps
// Per input beat: one history tap of the shared multiply-accumulate per cycle over the
// taps in play (at most W-1, W = effective window), then a one-bit-per-cycle restoring
// divider. Reset clears seen count and control state and sets config to width 5, mode 0.
// Throughput: one item at a time; next input taken once the result register
// is free. History cells are not reset.
// ----------------------------------------------------------------------------
// trailing_weighted_moving_average_unit
// Weighted trailing mean over a chain of history cells with serial divide.
// ----------------------------------------------------------------------------
module trailing_weighted_moving_average_unit #(
	parameter int MAX_WINDOW  = 32,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic                                   cfg_index,
	input  logic [twma_pkg::CFG_BITS-1:0]          cfg_wdata,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,  // sample
	input  logic                                   s_tlast,  // end_of_sequence
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,  // smoothed
	output logic                                   m_tlast   // last_out
);
	import twma_pkg::*;

	localparam int DBITS = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int DEPTH = MAX_WINDOW - 1;
	localparam int WB    = $clog2(MAX_WINDOW + 1);
	localparam int CB    = $clog2(MAX_WINDOW);
	localparam int SB    = 2 * WB + 1;
	localparam int ACCB  = SAMPLE_BITS + SB + 1;
	localparam int MAGB  = ACCB;
	localparam int DCB   = $clog2(MAGB + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MAC  = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]               state_q;
	logic [CFG_BITS-1:0]      width_q;
	logic                     mode_q;
	logic [CB-1:0]            seen_q;
	logic [SAMPLE_BITS-1:0]   x_q;
	logic                     last_q;
	logic [WB-1:0]            w_q;
	logic [CB-1:0]            k_q;
	logic [CB-1:0]            used_q;
	logic signed [ACCB-1:0]   acc_q;
	logic [SB-1:0]            wsum_q;
	logic [MAGB-1:0]          mag_q;
	logic [MAGB:0]            rem_q;
	logic [MAGB-1:0]          quo_q;
	logic [DCB-1:0]           dcnt_q;
	logic                     neg_q;
	logic [SAMPLE_BITS-1:0]   res_q;
	logic                     res_last_q;
	logic                     res_valid_q;

	logic                     accept;
	logic                     shift;
	logic [SAMPLE_BITS-1:0]   tap [DEPTH+1];
	logic [CFG_BITS-1:0]      wclip;
	logic [WB-1:0]            weff;
	logic [CB-1:0]            seen_lim;

	assign s_tready = (state_q == ST_IDLE) && !res_valid_q;
	assign accept   = s_tvalid && s_tready;
	// history moves only after the mean is done, so tap[1] is the newest older sample
	assign shift    = (state_q == ST_FIN) && !last_q;
	assign tap[0]   = x_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		twma_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
			.clk  (clk),
			.shift(shift),
			.din  (tap[i]),
			.dout (tap[i+1])
		);
	end

	always_comb begin
		wclip = (width_q == '0) ? CFG_BITS'(1) : width_q;
		if (32'(wclip) > MAX_WINDOW) begin
			weff = WB'(MAX_WINDOW);
		end else begin
			weff = WB'(wclip);
		end
		if (32'(seen_q) + 1 > 32'(weff)) begin
			seen_lim = CB'(weff - WB'(1));
		end else begin
			seen_lim = seen_q;
		end
	end

	logic signed [SAMPLE_BITS-1:0] tap_k;
	logic [WB-1:0]                 wk;
	logic signed [ACCB-1:0]        prod;
	logic [MAGB:0]                 trial;
	assign tap_k = signed'(tap[k_q + CB'(1)]);
	assign wk    = mode_q ? (w_q - WB'(k_q) - WB'(1)) : WB'(1);
	assign prod  = ACCB'(tap_k) * signed'({1'b0, wk});
	assign trial = {rem_q[MAGB-1:0], mag_q[MAGB-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			width_q     <= CFG_BITS'(5);
			mode_q      <= 1'b0;
			seen_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW_WIDTH: width_q <= cfg_wdata;
					REG_WEIGHT_MODE:  mode_q  <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MAC;
						if (s_tlast) begin
							seen_q <= '0;
						end else if (32'(seen_q) < DEPTH) begin
							seen_q <= seen_q + CB'(1);
						end
					end
				end
				ST_MAC: begin
					if (k_q == used_q) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: state_q <= ST_DIV;
				ST_DIV: begin
					if (dcnt_q == DCB'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q     <= ST_IDLE;
					res_valid_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					x_q    <= s_tdata[SAMPLE_BITS-1:0];
					last_q <= s_tlast;
					w_q    <= weff;
					used_q <= seen_lim;
					k_q    <= '0;
					acc_q  <= mode_q
						? ACCB'(signed'(s_tdata[SAMPLE_BITS-1:0])) * signed'({1'b0, weff})
						: ACCB'(signed'(s_tdata[SAMPLE_BITS-1:0]));
					wsum_q <= mode_q ? SB'(weff) : SB'(1);
				end
			end
			ST_MAC: begin
				if (k_q != used_q) begin
					acc_q  <= acc_q + prod;
					wsum_q <= wsum_q + SB'(wk);
				end
				k_q <= k_q + CB'(1);
			end
			ST_PREP: begin
				neg_q  <= acc_q[ACCB-1];
				mag_q  <= (acc_q[ACCB-1] ? MAGB'(-acc_q) : MAGB'(acc_q))
					+ MAGB'(wsum_q >> 1);
				rem_q  <= '0;
				dcnt_q <= DCB'(MAGB);
			end
			ST_DIV: begin
				if (trial >= (MAGB+1)'(wsum_q)) begin
					rem_q <= trial - (MAGB+1)'(wsum_q);
					quo_q <= {quo_q[MAGB-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[MAGB-2:0], 1'b0};
				end
				mag_q  <= {mag_q[MAGB-2:0], 1'b0};
				dcnt_q <= dcnt_q - DCB'(1);
			end
			ST_FIN: begin
				res_q      <= neg_q ? SAMPLE_BITS'(-quo_q) : SAMPLE_BITS'(quo_q);
				res_last_q <= last_q;
			end
			default: ;
		endcase
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = DBITS'(res_q);
	assign m_tlast  = res_last_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input taken while busy");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (32'(used_q) < 32'(w_q)))
		else $error("history use exceeds window");
	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> res_valid_q)
		else $error("result not posted");
	a_seen_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> (seen_q == '0))
		else $error("history not cleared at end of sequence");
endmodule

// ----- test/trailing_weighted_moving_average_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trailing_weighted_moving_average_unit_test
// Streams signed samples in runs ended by tlast through the moving average
// unit under several window and weighting settings. An in-bench predictor
// computes each rounded weighted mean; the monitor checks every output beat in order.
// ----------------------------------------------------------------------------
module trailing_weighted_moving_average_unit_test;
	import twma_pkg::*;

	localparam int MAXW  = 32;
	localparam int SBITS = 24;
	localparam int DW    = 24;
	localparam int WDOG  = 20000;

	typedef struct packed {
		logic [SBITS-1:0] sample;
		logic             eos;
	} sample_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_BITS-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DW-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [DW-1:0] m_tdata;
	logic m_tlast;

	sample_beat_t pending_samples[$];
	sample_beat_t expected_means[$];
	logic signed [SBITS-1:0] past_samples[MAXW-1];
	int  seen_cnt = 0;
	int  win_reg = 5;
	bit  linear_reg = 1'b0;
	int  errors = 0;
	int  idle_cycles = 0;
	int  hold_off = 0;
	int  feed_gap = 0;
	bit  sink_gap_en = 1'b1;
	int  drain_gap = 0;
	bit  in_taken = 1'b0;

	trailing_weighted_moving_average_unit dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic sample_beat_t predict_mean(sample_beat_t b);
		longint total, mag, q, wsum;
		int w, used;
		logic signed [SBITS-1:0] x;
		sample_beat_t r;
		x = b.sample;
		w = win_reg < 1 ? 1 : (win_reg > MAXW ? MAXW : win_reg);
		used = seen_cnt > w - 1 ? w - 1 : seen_cnt;
		if (linear_reg) begin
			total = longint'(x) * w;
			wsum = w;
			for (int k = 1; k <= used; k++) begin
				total += longint'(past_samples[k-1]) * (w - k);
				wsum += w - k;
			end
		end else begin
			total = x;
			wsum = 1 + used;
			for (int k = 1; k <= used; k++)
				total += past_samples[k-1];
		end
		mag = total < 0 ? -total : total;
		q = (mag + wsum / 2) / wsum;
		if (total < 0)
			q = -q;
		r.sample = q[SBITS-1:0];
		r.eos = b.eos;
		if (b.eos) begin
			seen_cnt = 0;
		end else begin
			for (int k = MAXW - 2; k > 0; k--)
				past_samples[k] = past_samples[k-1];
			past_samples[0] = x;
			if (seen_cnt < MAXW - 1)
				seen_cnt++;
		end
		return r;
	endfunction

	// input handshake seen at the clock edge
	always @(posedge clk) begin
		in_taken <= s_tvalid && s_tready;
	end

	// driver
	always @(negedge clk) begin
		if (in_taken) begin
			expected_means.push_back(predict_mean(pending_samples.pop_front()));
			feed_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
			if ($urandom_range(0, 99) == 0)
				feed_gap = $urandom_range(20, 150);
		end
		if (feed_gap > 0)
			feed_gap--;
		if (arst_n && pending_samples.size() > 0 && feed_gap == 0) begin
			s_tvalid <= 1'b1;
			s_tdata <= DW'(pending_samples[0].sample);
			s_tlast <= pending_samples[0].eos;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// sink stalls
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off--;
			m_tready <= 1'b0;
		end else if (drain_gap > 0) begin
			drain_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (sink_gap_en && $urandom_range(0, 5) == 0)
				drain_gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200)
					: $urandom_range(1, 3);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expected_means.size() == 0) begin
				$error("unexpected beat smoothed=%h last=%b", m_tdata, m_tlast);
				errors++;
			end else begin
				sample_beat_t e;
				e = expected_means.pop_front();
				if (m_tdata[SBITS-1:0] !== e.sample) begin
					$error("smoothed exp %h got %h", e.sample, m_tdata[SBITS-1:0]);
					errors++;
				end
				if (m_tlast !== e.eos) begin
					$error("last_out exp %b got %b", e.eos, m_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles = 0;
		else if (++idle_cycles >= WDOG) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(logic idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_BITS'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WINDOW_WIDTH)
			win_reg = val;
		else
			linear_reg = val[0];
	endtask

	task automatic wait_quiet();
		while (pending_samples.size() > 0 || expected_means.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic push_sample(logic [SBITS-1:0] v, logic eos);
		sample_beat_t b;
		b.sample = v;
		b.eos = eos;
		pending_samples.push_back(b);
	endtask

	function automatic logic [SBITS-1:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return SBITS'($urandom_range(0, 7)) - 24'd3;
			default: return SBITS'($urandom);
		endcase
	endfunction

	task automatic random_runs(int count);
		for (int i = 0; i < count; i++)
			push_sample(rand_sample(), $urandom_range(0, 11) == 0);
		push_sample(rand_sample(), 1'b1);
	endtask

	initial begin
		int settings[8][2];
		settings = '{'{0, 0}, '{1, 1}, '{32, 1}, '{63, 0}, '{33, 1}, '{7, 1},
			'{32, 0}, '{3, 1}};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// reset settings: extremes, signs, ties
		push_sample(24'h7FFFFF, 1'b0);
		push_sample(24'h7FFFFF, 1'b0);
		push_sample(24'h800000, 1'b0);
		push_sample(24'h800000, 1'b0);
		push_sample(24'h000001, 1'b0);
		push_sample(24'hFFFFFF, 1'b1);
		push_sample(24'h000001, 1'b0);
		push_sample(24'hFFFFFE, 1'b0);
		push_sample(24'h555555, 1'b0);
		push_sample(24'hAAAAAA, 1'b1);
		wait_quiet();
		// receiver holds off long while the sender keeps offering
		sink_gap_en = 1'b0;
		hold_off = 400;
		for (int i = 0; i < 8; i++)
			push_sample(rand_sample(), 1'b0);
		wait_quiet();
		sink_gap_en = 1'b1;
		foreach (settings[i]) begin
			write_reg(REG_WINDOW_WIDTH, settings[i][0]);
			write_reg(REG_WEIGHT_MODE, settings[i][1]);
			random_runs(60);
			// window change mid-sequence
			if (i == 5) begin
				for (int j = 0; j < 10; j++)
					push_sample(rand_sample(), 1'b0);
				wait_quiet();
				write_reg(REG_WINDOW_WIDTH, 32);
				random_runs(40);
			end
			random_runs(80);
			wait_quiet();
		end
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
